FILE: hdl/olirf_pkg.sv
// ----------------------------------------------------------------------------
// olirf_pkg
// Shared sizes, codes and control/status bundles for the ordered list unit.
// ----------------------------------------------------------------------------
package olirf_pkg;

  localparam int CAPACITY    = 64;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int LIM_W       = 7;
  localparam int CMP_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int KEY_W       = 40;
  localparam int VAL_W       = 32;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_BADPOS = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_NOKEY  = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch item, check it, commit count
    logic rd;        // read entry at ptr, step ptr
    logic shift_wr;  // write last read entry one slot over
    logic put;       // write the new entry at its slot
    logic hit;       // capture find match
  } olirf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_up;     // insert that needs a shift
    logic go_put;    // insert at the tail
    logic go_down;   // remove that needs a shift
    logic go_find;   // find on a non-empty list
    logic rd_last;   // ptr is at the last address to read
    logic rd_valid;  // read data register holds an entry
    logic match;     // read key equals search key
    logic is_ins;    // current item is an insert
  } olirf_stat_t;

endpackage

FILE: hdl/ordered_list_insert_remove_find_unit.sv
// Insert shifts entries at and above its slot up, then writes the new one; remove shifts the
//   entries above its slot down; find reads from slot 0 to a match; rejected items do no walk.
// Throughput: one item at a time; the next start is taken the cycle after done.
// The shift and search walk one entry per cycle through the entry memory's read port.
// Reset: count cleared, list_limit set to 64; entry memory is not cleared.
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_find_unit
// Packed ordered list of key/payload entries with insert, remove and find.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_find_unit (
  input  logic                        clk,
  input  logic                        rst,
  // item command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [6:0]                  position,
  input  logic [olirf_pkg::KEY_W-1:0] entry_key,
  input  logic [olirf_pkg::VAL_W-1:0] entry_value,
  // result, marked by a one-cycle done strobe per item
  output logic                        done,
  output logic [2:0]                  status,
  output logic [5:0]                  found_index,
  output logic [olirf_pkg::VAL_W-1:0] found_value,
  output logic [6:0]                  entry_count,
  // list_limit write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [olirf_pkg::LIM_W-1:0] cfg_data
);

  olirf_pkg::olirf_cmd_t  cmd;
  olirf_pkg::olirf_stat_t stat;

  // limit writes are registered whenever cfg_valid is high; always ready
  assign cfg_ready = 1'b1;

  // sequencer: decides the walk for each item and marks the reply
  olirf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  // entry memory, count, checks and result registers
  olirf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .position    (position),
    .entry_key   (entry_key),
    .entry_value (entry_value),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .found_index (found_index),
    .found_value (found_value),
    .entry_count (entry_count)
  );

endmodule

FILE: hdl/olirf_ctrl.sv
// ----------------------------------------------------------------------------
// olirf_ctrl
// Sequencer: steps shifts and searches over the entry memory.
// ----------------------------------------------------------------------------
module olirf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  olirf_pkg::olirf_stat_t stat,
  output olirf_pkg::olirf_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_UP    = 7'b0000010,
    S_DOWN  = 7'b0000100,
    S_FIND  = 7'b0001000,
    S_FWAIT = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_PUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        // the reply cycle still counts as busy, so no item is taken then
        if (start && !done) begin
          cmd.load = 1'b1;
          if (stat.go_up) begin
            state_next = S_UP;
          end else if (stat.go_put) begin
            state_next = S_PUT;
          end else if (stat.go_down) begin
            state_next = S_DOWN;
          end else if (stat.go_find) begin
            state_next = S_FIND;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      S_UP, S_DOWN: begin
        cmd.rd       = 1'b1;
        cmd.shift_wr = stat.rd_valid;
        if (stat.rd_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.shift_wr = 1'b1;
        if (stat.is_ins) begin
          state_next = S_PUT;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      S_FIND: begin
        if (stat.match) begin
          cmd.hit    = 1'b1;
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          cmd.rd = 1'b1;
          if (stat.rd_last) begin
            state_next = S_FWAIT;
          end
        end
      end
      S_FWAIT: begin
        cmd.hit    = stat.match;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // busy also covers the reply cycle so a new item waits for the strobe
  assign busy = (state != S_IDLE) || done;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("reply strobe while sequencer active");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift_wr && cmd.put))
    else $error("two memory writes in one cycle");
`endif

endmodule

FILE: hdl/olirf_dp.sv
// ----------------------------------------------------------------------------
// olirf_dp
// Entry memory, count, limit register, checks and result registers.
// ----------------------------------------------------------------------------
module olirf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          op,
  input  logic [6:0]                          position,
  input  logic [olirf_pkg::KEY_W-1:0]         entry_key,
  input  logic [olirf_pkg::VAL_W-1:0]         entry_value,
  input  logic                                cfg_valid,
  input  logic [olirf_pkg::LIM_W-1:0]         cfg_data,
  input  olirf_pkg::olirf_cmd_t                cmd,
  output olirf_pkg::olirf_stat_t               stat,
  output logic [2:0]                          status,
  output logic [5:0]                          found_index,
  output logic [olirf_pkg::VAL_W-1:0]         found_value,
  output logic [6:0]                          entry_count
);

  logic [olirf_pkg::KEY_W-1:0] mem_key [olirf_pkg::CAPACITY];
  logic [olirf_pkg::VAL_W-1:0] mem_val [olirf_pkg::CAPACITY];

  logic [olirf_pkg::CNT_W-1:0] count;
  logic [olirf_pkg::LIM_W-1:0] limit;
  logic                        is_ins;
  logic [olirf_pkg::IDX_W-1:0] pos_q;
  logic [olirf_pkg::KEY_W-1:0] key_q;
  logic [olirf_pkg::VAL_W-1:0] val_q;
  logic [olirf_pkg::IDX_W-1:0] ptr;
  logic [olirf_pkg::IDX_W-1:0] last_q;
  logic                        rd_valid;
  logic [olirf_pkg::IDX_W-1:0] rd_addr_q;
  logic [olirf_pkg::KEY_W-1:0] rd_key;
  logic [olirf_pkg::VAL_W-1:0] rd_val;
  olirf_pkg::status_t          status_q;
  logic [olirf_pkg::IDX_W-1:0] found_q;
  logic [olirf_pkg::VAL_W-1:0] fval_q;

  // item checks, taken against the live input ports at accept
  logic [olirf_pkg::CMP_W-1:0] cnt_w, lim_w, pos_w;
  logic op_ins, op_rem, op_find;
  logic full, ins_bad, empty, rem_bad, at_tail;

  always_comb begin
    cnt_w   = olirf_pkg::CMP_W'(count);
    lim_w   = olirf_pkg::CMP_W'(limit);
    pos_w   = olirf_pkg::CMP_W'(position);
    op_ins  = (op == olirf_pkg::OP_INSERT);
    op_rem  = (op == olirf_pkg::OP_REMOVE);
    op_find = (op == olirf_pkg::OP_FIND);
    full    = (cnt_w >= lim_w) || (count == olirf_pkg::CNT_W'(olirf_pkg::CAPACITY));
    ins_bad = (pos_w > cnt_w);
    empty   = (count == '0);
    rem_bad = (position == 7'd0) || (pos_w > cnt_w);
    at_tail = (pos_w == cnt_w);
  end

  assign stat.go_up    = op_ins && !full && !ins_bad && !at_tail;
  assign stat.go_put   = op_ins && !full && !ins_bad && at_tail;
  assign stat.go_down  = op_rem && !empty && !rem_bad && !at_tail;
  assign stat.go_find  = op_find && !empty;
  assign stat.rd_last  = (ptr == last_q);
  assign stat.rd_valid = rd_valid;
  assign stat.match    = rd_valid && (rd_key == key_q);
  assign stat.is_ins   = is_ins;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      limit    <= olirf_pkg::LIMIT_RESET;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd;
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      // count is committed at accept; later steps use last_q instead
      if (cmd.load) begin
        if (op_ins && !full && !ins_bad) begin
          count <= count + olirf_pkg::CNT_W'(1);
        end else if (op_rem && !empty && !rem_bad) begin
          count <= count - olirf_pkg::CNT_W'(1);
        end
      end
    end
  end

  // item, walk pointer and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_ins  <= op_ins;
      pos_q   <= olirf_pkg::IDX_W'(position);
      key_q   <= entry_key;
      val_q   <= entry_value;
      found_q <= '0;
      fval_q  <= '0;
      if (op_ins) begin
        ptr    <= olirf_pkg::IDX_W'(count - olirf_pkg::CNT_W'(1));
        last_q <= olirf_pkg::IDX_W'(position);
      end else if (op_rem) begin
        ptr    <= olirf_pkg::IDX_W'(position);
        last_q <= olirf_pkg::IDX_W'(count - olirf_pkg::CNT_W'(1));
      end else begin
        ptr    <= '0;
        last_q <= olirf_pkg::IDX_W'(count - olirf_pkg::CNT_W'(1));
      end
      if (op_ins) begin
        status_q <= full ? olirf_pkg::ST_FULL :
                    ins_bad ? olirf_pkg::ST_BADPOS : olirf_pkg::ST_OK;
      end else if (op_rem) begin
        status_q <= empty ? olirf_pkg::ST_EMPTY :
                    rem_bad ? olirf_pkg::ST_BADPOS : olirf_pkg::ST_OK;
      end else if (op_find) begin
        status_q <= olirf_pkg::ST_NOKEY;
      end else begin
        status_q <= olirf_pkg::ST_OK;
      end
    end else begin
      if (cmd.rd) begin
        ptr <= is_ins ? ptr - olirf_pkg::IDX_W'(1) : ptr + olirf_pkg::IDX_W'(1);
      end
      if (cmd.hit) begin
        status_q <= olirf_pkg::ST_OK;
        found_q  <= rd_addr_q;
        fval_q   <= rd_val;
      end
    end
  end

  // entry memory: one registered read port, one write port
  logic                        wr_en;
  logic [olirf_pkg::IDX_W-1:0] wr_addr;
  logic [olirf_pkg::KEY_W-1:0] wr_key;
  logic [olirf_pkg::VAL_W-1:0] wr_val;

  always_comb begin
    wr_en = cmd.shift_wr || cmd.put;
    if (cmd.put) begin
      wr_addr = pos_q;
      wr_key  = key_q;
      wr_val  = val_q;
    end else begin
      wr_addr = is_ins ? rd_addr_q + olirf_pkg::IDX_W'(1) : rd_addr_q - olirf_pkg::IDX_W'(1);
      wr_key  = rd_key;
      wr_val  = rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key    <= mem_key[ptr];
      rd_val    <= mem_val[ptr];
      rd_addr_q <= ptr;
    end
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_val[wr_addr] <= wr_val;
    end
  end

  assign status      = status_q;
  assign found_index = 6'(found_q);
  assign found_value = fval_q;
  assign entry_count = 7'(count);

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= olirf_pkg::CNT_W'(olirf_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.hit |=> (status_q == olirf_pkg::ST_OK))
    else $error("find hit not reported as ok");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (fval_q != '0 || found_q != '0) |-> (status_q == olirf_pkg::ST_OK))
    else $error("found fields set on a failed item");
`endif

endmodule
